// ===== rtl/core/transformed_vertex_bounding_box_core_macros.svh =====
// Assertion helpers shared by the bounding box core.
`ifndef TRANSFORMED_VERTEX_BOUNDING_BOX_CORE_MACROS_SVH
`define TRANSFORMED_VERTEX_BOUNDING_BOX_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TVBB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TVBB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tvbb_pkg.sv =====
package tvbb_pkg;

  localparam int COORD_W   = 32;
  localparam int RADIUS_W  = 31;
  localparam int ROT_W     = 16;
  localparam int ROT_FRAC  = 14;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 32;

  localparam int PROD_W  = COORD_W + ROT_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int SHIFT_W = SUM_W - ROT_FRAC;
  localparam int ACC_W   = SHIFT_W + 1;

  localparam logic [SUM_W-1:0]   ROUND_HALF = SUM_W'(1) << (ROT_FRAC - 1);
  localparam logic [COORD_W-1:0] COORD_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN  = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic [ROT_W-1:0]   ROT_COS_RESET = ROT_W'(16384);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_COS = CFG_IDX_W'(0),
    REG_ROT_SIN = CFG_IDX_W'(1),
    REG_POS_X   = CFG_IDX_W'(2),
    REG_POS_Y   = CFG_IDX_W'(3)
  } tvbb_reg_t;

  typedef struct packed {
    logic [ROT_W-1:0]   rot_cos;
    logic [ROT_W-1:0]   rot_sin;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
  } tvbb_cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0]  vertex_x;
    logic [COORD_W-1:0]  vertex_y;
    logic [RADIUS_W-1:0] shape_radius;
    logic                end_of_shape;
    logic                end_of_body;
  } tvbb_vertex_t;

  // Transformed vertex handed from the transform pipe to the box fold.
  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [RADIUS_W-1:0] radius;
    logic                closing;
    logic                last;
  } tvbb_point_t;

  typedef struct packed {
    logic [COORD_W-1:0] lower_x;
    logic [COORD_W-1:0] lower_y;
    logic [COORD_W-1:0] upper_x;
    logic [COORD_W-1:0] upper_y;
  } tvbb_box_t;

  function automatic logic [COORD_W-1:0] sat32(input logic [ACC_W-1:0] v);
    if (v[ACC_W-1:COORD_W-1] == {(ACC_W-COORD_W+1){v[ACC_W-1]}}) begin
      return v[COORD_W-1:0];
    end else if (v[ACC_W-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

  function automatic logic [ACC_W-1:0] sext_coord(input logic [COORD_W-1:0] v);
    return {{(ACC_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic [COORD_W-1:0] smin(input logic [COORD_W-1:0] a,
                                               input logic [COORD_W-1:0] b);
    return ($signed(b) < $signed(a)) ? b : a;
  endfunction

  function automatic logic [COORD_W-1:0] smax(input logic [COORD_W-1:0] a,
                                               input logic [COORD_W-1:0] b);
    return ($signed(b) > $signed(a)) ? b : a;
  endfunction

endpackage

// ===== rtl/core/tvbb_if.sv =====
interface tvbb_vtx_if
  import tvbb_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  vertex_x;
  logic [COORD_W-1:0]  vertex_y;
  logic [RADIUS_W-1:0] shape_radius;
  logic                end_of_shape;
  logic                end_of_body;

  modport source (output valid, vertex_x, vertex_y, shape_radius, end_of_shape,
                  end_of_body, input ready);
  modport sink (input valid, vertex_x, vertex_y, shape_radius, end_of_shape,
                end_of_body, output ready);
endinterface

interface tvbb_box_if
  import tvbb_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] lower_x;
  logic [COORD_W-1:0] lower_y;
  logic [COORD_W-1:0] upper_x;
  logic [COORD_W-1:0] upper_y;

  modport source (output valid, lower_x, lower_y, upper_x, upper_y, input ready);
  modport sink (input valid, lower_x, lower_y, upper_x, upper_y, output ready);
endinterface

interface tvbb_cfg_if
  import tvbb_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tvbb_xform.sv =====
module tvbb_xform
  import tvbb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  tvbb_cfg_t    cfg_regs,
  input  logic         in_valid,
  output logic         in_ready,
  input  tvbb_vertex_t in_vtx,
  output logic         out_valid,
  input  logic         out_ready,
  output tvbb_point_t  out_pt
);

  typedef struct packed {
    logic [PROD_W-1:0]   cx;
    logic [PROD_W-1:0]   sy;
    logic [PROD_W-1:0]   sx;
    logic [PROD_W-1:0]   cy;
    logic [RADIUS_W-1:0] radius;
    logic                eos;
    logic                eob;
  } prod_t;

  logic         r1_valid, r2_valid, r3_valid;
  tvbb_vertex_t r1;
  prod_t        r2, r2_next;
  tvbb_point_t  r3, r3_next;
  logic         r1_free, r2_free, r3_free;

  logic [SUM_W-1:0]   sum_x, sum_y, rnd_x, rnd_y;
  logic [SHIFT_W-1:0] sh_x, sh_y;
  logic [ACC_W-1:0]   acc_x, acc_y;

  // Each stage refills when it is empty or its item moves on.
  assign r3_free  = !r3_valid || out_ready;
  assign r2_free  = !r2_valid || r3_free;
  assign r1_free  = !r1_valid || r2_free;
  assign in_ready = r1_free;

  always_comb begin
    r2_next.cx     = PROD_W'($signed(cfg_regs.rot_cos) * $signed(r1.vertex_x));
    r2_next.sy     = PROD_W'($signed(cfg_regs.rot_sin) * $signed(r1.vertex_y));
    r2_next.sx     = PROD_W'($signed(cfg_regs.rot_sin) * $signed(r1.vertex_x));
    r2_next.cy     = PROD_W'($signed(cfg_regs.rot_cos) * $signed(r1.vertex_y));
    r2_next.radius = r1.shape_radius;
    r2_next.eos    = r1.end_of_shape;
    r2_next.eob    = r1.end_of_body;
  end

  always_comb begin
    sum_x = {r2.cx[PROD_W-1], r2.cx} - {r2.sy[PROD_W-1], r2.sy};
    sum_y = {r2.sx[PROD_W-1], r2.sx} + {r2.cy[PROD_W-1], r2.cy};
    rnd_x = sum_x + ROUND_HALF;
    rnd_y = sum_y + ROUND_HALF;
    // floor after adding half: ties round toward +inf
    sh_x  = rnd_x[SUM_W-1:ROT_FRAC];
    sh_y  = rnd_y[SUM_W-1:ROT_FRAC];
    acc_x = {sh_x[SHIFT_W-1], sh_x} + sext_coord(cfg_regs.pos_x);
    acc_y = {sh_y[SHIFT_W-1], sh_y} + sext_coord(cfg_regs.pos_y);
    r3_next.x       = sat32(acc_x);
    r3_next.y       = sat32(acc_y);
    r3_next.radius  = r2.radius;
    r3_next.closing = r2.eos | r2.eob;
    r3_next.last    = r2.eob;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
      r2_valid <= 1'b0;
      r3_valid <= 1'b0;
    end else begin
      if (r1_free) begin
        r1_valid <= in_valid;
      end
      if (r2_free) begin
        r2_valid <= r1_valid;
      end
      if (r3_free) begin
        r3_valid <= r2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1_free) begin
      r1 <= in_vtx;
    end
    if (r2_free) begin
      r2 <= r2_next;
    end
    if (r3_free) begin
      r3 <= r3_next;
    end
  end

  assign out_valid = r3_valid;
  assign out_pt    = r3;

endmodule

// ===== rtl/core/tvbb_fold.sv =====
module tvbb_fold
  import tvbb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  tvbb_point_t in_pt,
  output logic        out_valid,
  input  logic        out_ready,
  output tvbb_box_t   out_box
);

`include "transformed_vertex_bounding_box_core_macros.svh"

  tvbb_box_t           shape, shape_next;
  logic                shape_empty;
  tvbb_box_t           closed;
  logic [RADIUS_W-1:0] closed_radius;
  logic                closed_last;
  logic                closed_valid;
  tvbb_box_t           widened;
  tvbb_box_t           body, body_next;
  logic                body_empty;
  tvbb_box_t           box_q;
  logic                box_valid;
  logic [ACC_W-1:0]    rad_ext;
  logic                closed_go, closed_free, in_fire, closed_fire;

  assign closed_go   = !closed_last || !box_valid || out_ready;
  assign closed_free = !closed_valid || closed_go;
  assign in_ready    = !in_pt.closing || closed_free;
  assign in_fire     = in_valid && in_ready;
  assign closed_fire = closed_valid && closed_go;

  always_comb begin
    if (shape_empty) begin
      shape_next = '{lower_x: in_pt.x, lower_y: in_pt.y,
                     upper_x: in_pt.x, upper_y: in_pt.y};
    end else begin
      shape_next.lower_x = smin(shape.lower_x, in_pt.x);
      shape_next.lower_y = smin(shape.lower_y, in_pt.y);
      shape_next.upper_x = smax(shape.upper_x, in_pt.x);
      shape_next.upper_y = smax(shape.upper_y, in_pt.y);
    end
  end

  always_comb begin
    rad_ext = {{(ACC_W-RADIUS_W){1'b0}}, closed_radius};
    widened.lower_x = sat32(sext_coord(closed.lower_x) - rad_ext);
    widened.lower_y = sat32(sext_coord(closed.lower_y) - rad_ext);
    widened.upper_x = sat32(sext_coord(closed.upper_x) + rad_ext);
    widened.upper_y = sat32(sext_coord(closed.upper_y) + rad_ext);
    if (body_empty) begin
      body_next = widened;
    end else begin
      body_next.lower_x = smin(body.lower_x, widened.lower_x);
      body_next.lower_y = smin(body.lower_y, widened.lower_y);
      body_next.upper_x = smax(body.upper_x, widened.upper_x);
      body_next.upper_y = smax(body.upper_y, widened.upper_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_empty  <= 1'b1;
      body_empty   <= 1'b1;
      closed_valid <= 1'b0;
      box_valid    <= 1'b0;
    end else begin
      if (in_fire) begin
        shape_empty <= in_pt.closing;
      end
      if (closed_free) begin
        closed_valid <= in_valid && in_pt.closing;
      end
      if (closed_fire) begin
        body_empty <= closed_last;
      end
      if (closed_fire && closed_last) begin
        box_valid <= 1'b1;
      end else if (out_ready) begin
        box_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !in_pt.closing) begin
      shape <= shape_next;
    end
    if (closed_free) begin
      closed        <= shape_next;
      closed_radius <= in_pt.radius;
      closed_last   <= in_pt.last;
    end
    if (closed_fire) begin
      if (closed_last) begin
        box_q <= body_next;
      end else begin
        body <= body_next;
      end
    end
  end

  assign out_valid = box_valid;
  assign out_box   = box_q;

  `TVBB_ASSERT_NOW(a_shape_order, clk, rst, !shape_empty,
    $signed(shape.lower_x) <= $signed(shape.upper_x) &&
    $signed(shape.lower_y) <= $signed(shape.upper_y), "shape box corners crossed")
  `TVBB_ASSERT_NOW(a_body_order, clk, rst, !body_empty,
    $signed(body.lower_x) <= $signed(body.upper_x) &&
    $signed(body.lower_y) <= $signed(body.upper_y), "body box corners crossed")
  `TVBB_ASSERT_NEXT(a_emit_clears, clk, rst, closed_fire && closed_last,
    body_empty && box_valid, "body end did not emit and clear")
  `TVBB_ASSERT_NEXT(a_close_clears, clk, rst, in_fire && in_pt.closing,
    shape_empty && closed_valid, "shape end did not hand off and clear")

endmodule

// ===== rtl/core/transformed_vertex_bounding_box_core.sv =====
// Bounding box of a rigidly transformed 2D body. Each vertex request
// carries a local Q16.16 point; the core rotates it by rot_cos/rot_sin
// (Q2.14, round half up), adds pos_x/pos_y, saturates to 32 bits and folds
// it into the current shape box. A vertex flagged end_of_shape (or
// end_of_body) closes the shape: its box is widened by shape_radius on
// every side with saturation and merged into the body box. A vertex flagged
// end_of_body also emits the body box as one result request and clears
// both boxes; every other vertex produces no result. Throughput is one
// vertex per clock unless the result side stalls. Vertices pass an input
// register, a register after the four 32x16 multipliers and a register
// after the round/offset/saturate adders, then update the shape box; a
// closing vertex also loads the closed shape register, which merges into
// the body box. Back pressure on the result side stalls only when a further
// body end reaches the merge stage while the previous result is still
// unread. Write rot_cos (index 0), rot_sin (1), pos_x (2), pos_y (3) only
// while no vertex is in flight; other indices are ignored.
module transformed_vertex_bounding_box_core
  import tvbb_pkg::*;
(
  input logic      clk,
  input logic      rst,
  tvbb_cfg_if.sink cfg,
  tvbb_vtx_if.sink vtx,
  tvbb_box_if.source box
);

  tvbb_cfg_t    cfg_regs;
  tvbb_vertex_t vtx_in;
  tvbb_point_t  pt;
  logic         pt_valid, pt_ready;
  tvbb_box_t    box_out;

  // Register writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.rot_cos <= ROT_COS_RESET;
      cfg_regs.rot_sin <= '0;
      cfg_regs.pos_x   <= '0;
      cfg_regs.pos_y   <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ROT_COS: cfg_regs.rot_cos <= cfg.data[ROT_W-1:0];
        REG_ROT_SIN: cfg_regs.rot_sin <= cfg.data[ROT_W-1:0];
        REG_POS_X:   cfg_regs.pos_x   <= cfg.data[COORD_W-1:0];
        REG_POS_Y:   cfg_regs.pos_y   <= cfg.data[COORD_W-1:0];
        default: begin
          // drop writes to unused indices
        end
      endcase
    end
  end

  // Gather the vertex request fields into one payload.
  assign vtx_in.vertex_x     = vtx.vertex_x;
  assign vtx_in.vertex_y     = vtx.vertex_y;
  assign vtx_in.shape_radius = vtx.shape_radius;
  assign vtx_in.end_of_shape = vtx.end_of_shape;
  assign vtx_in.end_of_body  = vtx.end_of_body;

  // Rotate, round, translate and saturate.
  tvbb_xform u_xform (
    .clk       (clk),
    .rst       (rst),
    .cfg_regs  (cfg_regs),
    .in_valid  (vtx.valid),
    .in_ready  (vtx.ready),
    .in_vtx    (vtx_in),
    .out_valid (pt_valid),
    .out_ready (pt_ready),
    .out_pt    (pt)
  );

  // Shape and body min/max, radius widening and result register.
  tvbb_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pt_valid),
    .in_ready  (pt_ready),
    .in_pt     (pt),
    .out_valid (box.valid),
    .out_ready (box.ready),
    .out_box   (box_out)
  );

  assign box.lower_x = box_out.lower_x;
  assign box.lower_y = box_out.lower_y;
  assign box.upper_x = box_out.upper_x;
  assign box.upper_y = box_out.upper_y;

endmodule
